/* src/mrfe_pkg.sv */
package mrfe_pkg;

  localparam int FRAME_MAX_BYTES = 256;
  localparam int CNT_W = $clog2(FRAME_MAX_BYTES + 1);
  localparam int MIN_REPLY_BYTES = 4;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = ADDR_W'(0);
  localparam logic [15:0] TIMEOUT_RESET = 16'd300;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    REQ_TX_BYTE    = 3'd0,
    REQ_TX_END     = 3'd1,
    REQ_RX_BYTE    = 3'd2,
    REQ_RX_SILENCE = 3'd3,
    REQ_TICK       = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_BAD_CRC   = 3'd1,
    VERDICT_BAD_UNIT  = 3'd2,
    VERDICT_OVERFLOW  = 3'd3,
    VERDICT_TOO_SHORT = 3'd4,
    VERDICT_TIMEOUT   = 3'd5
  } verdict_t;

  typedef struct packed {
    logic             kind;
    logic             last;
    logic [CNT_W-1:0] frame_length;
    verdict_t         verdict;
    logic             drive_enable;
    logic [7:0]       line_byte;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/modbus_rtu_frame_engine.sv */
// Modbus RTU master framing engine.
// Slave stream: s_tuser carries the request kind (tx byte, tx end, rx byte,
// rx silence, tick), s_tdata the frame byte. Master stream: zero, one or two
// results per request; m_tuser says line byte or receive verdict, m_tlast
// marks the last result of a request. Tx bytes come back out as line bytes
// with drive enable set; tx end appends the CRC-16 low and high bytes and
// opens the response window. Rx bytes build the reply CRC through a
// two-byte hold; silence or a timed-out window gives the verdict.
// Timing: each result is registered in the output queue before it reaches the master stream.
// Throughput: one request per cycle while s_tready is high; a tx end puts two
// results into the four-entry output queue, so a continuous run of tx ends
// drains at one result per cycle and the input is held off between tx ends.
// When the receiver stalls, the queue fills and s_tready drops once fewer
// than two entries are free; nothing is lost.
// Reset (rst, synchronous) empties the queue, clears the CRC and receive
// state, closes the window and sets the timeout register to 300 ticks.
// The APB port holds response_timeout_ticks at address 0.
module modbus_rtu_frame_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // data_byte
  input  logic [2:0]                    s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // line_byte, drive_enable, verdict,
                                                   // frame_length, zero pad
  output logic                          m_tuser,   // result_kind
  output logic                          m_tlast,   // last_of_run
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrfe_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CNT_W = mrfe_pkg::CNT_W;

  logic [15:0]      response_timeout_ticks;
  logic [15:0]      tx_crc, tx_crc_next;
  logic             tx_first_pending, tx_first_pending_next;
  logic [7:0]       request_unit, request_unit_next;
  logic             awaiting_reply, awaiting_reply_next;
  logic [15:0]      reply_timer, reply_timer_next;
  logic [15:0]      rx_crc, rx_crc_next;
  logic [15:0]      rx_hold, rx_hold_next;
  logic [7:0]       rx_first_byte, rx_first_byte_next;
  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic             rx_overflowed, rx_overflowed_next;

  mrfe_pkg::result_t fifo [mrfe_pkg::FIFO_DEPTH];
  logic [mrfe_pkg::PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [mrfe_pkg::FILL_W-1:0] fill;

  mrfe_pkg::result_t res0, res1;
  logic [1:0]        push_n;
  logic              in_xfer, out_xfer;
  mrfe_pkg::req_t    req;
  mrfe_pkg::result_t head;

  assign req      = mrfe_pkg::req_t'(s_tuser);
  assign s_tready = fill <= mrfe_pkg::FILL_W'(mrfe_pkg::FIFO_DEPTH - 2);
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tvalid = fill != '0;
  assign out_xfer = m_tvalid && m_tready;
  assign head     = fifo[rd_ptr];
  assign m_tdata  = {3'b000, head.frame_length, head.verdict, head.drive_enable,
                     head.line_byte};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  assign pready = 1'b1;
  assign prdata = (paddr == mrfe_pkg::ADDR_TIMEOUT) ? {16'h0000, response_timeout_ticks}
                                                    : 32'h0000_0000;

  always_comb begin
    tx_crc_next           = tx_crc;
    tx_first_pending_next = tx_first_pending;
    request_unit_next     = request_unit;
    awaiting_reply_next   = awaiting_reply;
    reply_timer_next      = reply_timer;
    rx_crc_next           = rx_crc;
    rx_hold_next          = rx_hold;
    rx_first_byte_next    = rx_first_byte;
    rx_count_next         = rx_count;
    rx_overflowed_next    = rx_overflowed;
    res0                  = '0;
    res1                  = '0;
    push_n                = 2'd0;
    unique case (req)
      mrfe_pkg::REQ_TX_BYTE: begin
        if (tx_first_pending) begin
          request_unit_next     = s_tdata;
          tx_first_pending_next = 1'b0;
        end
        tx_crc_next       = mrfe_pkg::crc_feed(tx_crc, s_tdata);
        res0.kind         = mrfe_pkg::KIND_LINE;
        res0.line_byte    = s_tdata;
        res0.drive_enable = 1'b1;
        res0.last         = 1'b1;
        push_n            = 2'd1;
      end
      mrfe_pkg::REQ_TX_END: begin
        res0.kind             = mrfe_pkg::KIND_LINE;
        res0.line_byte        = tx_crc[7:0];
        res0.drive_enable     = 1'b1;
        res1.kind             = mrfe_pkg::KIND_LINE;
        res1.line_byte        = tx_crc[15:8];
        res1.drive_enable     = 1'b1;
        res1.last             = 1'b1;
        push_n                = 2'd2;
        tx_crc_next           = mrfe_pkg::CRC_INIT;
        tx_first_pending_next = 1'b1;
        awaiting_reply_next   = 1'b1;
        reply_timer_next      = response_timeout_ticks;
        rx_crc_next           = mrfe_pkg::CRC_INIT;
        rx_hold_next          = '0;
        rx_first_byte_next    = '0;
        rx_count_next         = '0;
        rx_overflowed_next    = 1'b0;
      end
      mrfe_pkg::REQ_RX_BYTE: begin
        if (awaiting_reply) begin
          if (rx_count >= CNT_W'(mrfe_pkg::FRAME_MAX_BYTES)) begin
            rx_overflowed_next = 1'b1;
          end else begin
            if (rx_count >= CNT_W'(2)) begin
              rx_crc_next = mrfe_pkg::crc_feed(rx_crc, rx_hold[7:0]);
            end
            rx_hold_next = {s_tdata, rx_hold[15:8]};
            if (rx_count == '0) begin
              rx_first_byte_next = s_tdata;
            end
            rx_count_next = rx_count + CNT_W'(1);
          end
        end
      end
      mrfe_pkg::REQ_RX_SILENCE: begin
        if (awaiting_reply && rx_count != '0) begin
          res0.kind         = mrfe_pkg::KIND_VERDICT;
          res0.last         = 1'b1;
          res0.frame_length = (rx_count >= CNT_W'(2)) ? rx_count - CNT_W'(2) : '0;
          if (rx_overflowed) begin
            res0.verdict = mrfe_pkg::VERDICT_OVERFLOW;
          end else if (rx_count < CNT_W'(mrfe_pkg::MIN_REPLY_BYTES)) begin
            res0.verdict = mrfe_pkg::VERDICT_TOO_SHORT;
          end else if (rx_crc != rx_hold) begin
            res0.verdict = mrfe_pkg::VERDICT_BAD_CRC;
          end else if (rx_first_byte != request_unit) begin
            res0.verdict = mrfe_pkg::VERDICT_BAD_UNIT;
          end else begin
            res0.verdict = mrfe_pkg::VERDICT_OK;
          end
          push_n              = 2'd1;
          awaiting_reply_next = 1'b0;
          rx_crc_next         = mrfe_pkg::CRC_INIT;
          rx_hold_next        = '0;
          rx_first_byte_next  = '0;
          rx_count_next       = '0;
          rx_overflowed_next  = 1'b0;
        end
      end
      mrfe_pkg::REQ_TICK: begin
        if (awaiting_reply) begin
          if (reply_timer <= 16'd1) begin
            reply_timer_next    = '0;
            awaiting_reply_next = 1'b0;
            rx_crc_next         = mrfe_pkg::CRC_INIT;
            rx_hold_next        = '0;
            rx_first_byte_next  = '0;
            rx_count_next       = '0;
            rx_overflowed_next  = 1'b0;
            res0.kind           = mrfe_pkg::KIND_VERDICT;
            res0.verdict        = mrfe_pkg::VERDICT_TIMEOUT;
            res0.last           = 1'b1;
            push_n              = 2'd1;
          end else begin
            reply_timer_next = reply_timer - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_timeout_ticks <= mrfe_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == mrfe_pkg::ADDR_TIMEOUT) begin
      response_timeout_ticks <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_crc           <= mrfe_pkg::CRC_INIT;
      tx_first_pending <= 1'b1;
      request_unit     <= '0;
      awaiting_reply   <= 1'b0;
      reply_timer      <= '0;
      rx_crc           <= mrfe_pkg::CRC_INIT;
      rx_hold          <= '0;
      rx_first_byte    <= '0;
      rx_count         <= '0;
      rx_overflowed    <= 1'b0;
    end else if (in_xfer) begin
      tx_crc           <= tx_crc_next;
      tx_first_pending <= tx_first_pending_next;
      request_unit     <= request_unit_next;
      awaiting_reply   <= awaiting_reply_next;
      reply_timer      <= reply_timer_next;
      rx_crc           <= rx_crc_next;
      rx_hold          <= rx_hold_next;
      rx_first_byte    <= rx_first_byte_next;
      rx_count         <= rx_count_next;
      rx_overflowed    <= rx_overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && push_n != 2'd0) begin
      fifo[wr_ptr] <= res0;
      if (push_n == 2'd2) begin
        fifo[wr_ptr + mrfe_pkg::PTR_W'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + mrfe_pkg::PTR_W'(push_n);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + mrfe_pkg::PTR_W'(1);
      end
      fill <= fill + (in_xfer ? mrfe_pkg::FILL_W'(push_n) : '0)
                   - (out_xfer ? mrfe_pkg::FILL_W'(1) : '0);
    end
  end

endmodule
